// ===== rtl/core/sda_pkg.sv =====
// Shared types, constants and helpers for the switch debounce / auto-repeat block.
// No dependencies; imported by every module of the block.
package sda_pkg;

  localparam int SWITCHES  = 16;
  localparam int SAMPLE_W  = 16;
  localparam int CNT_W     = 16;
  localparam int IDX_W     = (SWITCHES > 1) ? $clog2(SWITCHES) : 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] SAT = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_ON_DEB     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_DEB    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REP_DELAY  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REP_PERIOD = 2'd3;

  localparam logic [CNT_W-1:0] RST_ON_DEB     = 16'd4;
  localparam logic [CNT_W-1:0] RST_OFF_DEB    = 16'd32;
  localparam logic [CNT_W-1:0] RST_REP_DELAY  = 16'd0;
  localparam logic [CNT_W-1:0] RST_REP_PERIOD = 16'd500;

  localparam logic CMD_COLLECT = 1'b1;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic                cmd;
    logic [SAMPLE_W-1:0] raw_sample;
  } sda_in_t;

  typedef struct packed {
    logic [3:0]       switch_index;
    logic             switch_pressed;
    logic [CNT_W-1:0] press_count;
    logic             last;
  } sda_out_t;

  typedef struct packed {
    logic [CNT_W-1:0] on_deb;
    logic [CNT_W-1:0] off_deb;
    logic [CNT_W-1:0] rep_delay;
    logic [CNT_W-1:0] rep_period;
  } sda_cfg_t;

  typedef enum logic {
    OP_TICK,
    OP_COLLECT
  } sda_op_t;

  typedef struct packed {
    sda_op_t             op;
    logic [SAMPLE_W-1:0] sample;
  } sda_item_t;

  typedef struct packed {
    logic             tick;
    logic             clr;
    logic [IDX_W-1:0] clr_idx;
  } sda_lane_ctl_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == SAT) ? v : v + 1'b1;
  endfunction

endpackage

// ===== rtl/core/switch_debounce_autorepeat.sv =====
// Switch debounce with auto-repeat. A tick passes through the two-entry input
// queue into the execution stage; one tick per cycle while no collect is running.
// A collect emits SWITCHES results, one per cycle as the output is taken; the
// first is registered after the collect leaves the queue, ticks wait in the queue meanwhile.
// Synchronous reset clears all counters, presses and tallies, empties the
// queue and restores the register defaults.
module switch_debounce_autorepeat import sda_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sda_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sda_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data
);

  sda_cfg_t                       cfg;
  logic                           q_valid;
  logic                           q_ready;
  sda_item_t                      q_item;
  sda_lane_ctl_t                  ctl;
  logic [SWITCHES-1:0]            pressed;
  logic [SWITCHES-1:0][CNT_W-1:0] tally;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_deb     <= RST_ON_DEB;
      cfg.off_deb    <= RST_OFF_DEB;
      cfg.rep_delay  <= RST_REP_DELAY;
      cfg.rep_period <= RST_REP_PERIOD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ON_DEB:     cfg.on_deb     <= cfg_data;
        REG_OFF_DEB:    cfg.off_deb    <= cfg_data;
        REG_REP_DELAY:  cfg.rep_delay  <= cfg_data;
        REG_REP_PERIOD: cfg.rep_period <= cfg_data;
        default: ;
      endcase
    end
  end

  sda_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  for (genvar i = 0; i < SWITCHES; i++) begin : g_lane
    sda_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .cfg     (cfg),
      .tick    (ctl.tick),
      .raw_bit (q_item.sample[i % SAMPLE_W]),
      .clr     (ctl.clr && (ctl.clr_idx == IDX_W'(i))),
      .pressed (pressed[i]),
      .tally   (tally[i])
    );
  end

  sda_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .pressed   (pressed),
    .tally     (tally),
    .ctl       (ctl),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/sda_front.sv =====
// Input side: accepts transfers, decodes the command and queues them.
// Depends on sda_pkg.
module sda_front import sda_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  sda_in_t   in_data,
  output logic      q_valid,
  input  logic      q_ready,
  output sda_item_t q_item
);

  sda_item_t          mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               push;
  logic               pop;
  sda_item_t          item_in;

  assign in_ready = (count != Q_CNT_W'(Q_DEPTH));
  assign q_valid  = (count != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_item   = mem[rd_ptr];

  always_comb begin
    item_in.op     = (in_data.cmd == CMD_COLLECT) ? OP_COLLECT : OP_TICK;
    item_in.sample = in_data.raw_sample;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count == Q_CNT_W'(Q_DEPTH)) |-> !push)
    else $error("queue written while full");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost a push");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !pop)
    else $error("queue read while empty");

endmodule

// ===== rtl/core/sda_lane.sv =====
// One switch: debounce run counters, held time, repeat phase and press tally.
// Depends on sda_pkg.
module sda_lane import sda_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  sda_cfg_t         cfg,
  input  logic             tick,
  input  logic             raw_bit,
  input  logic             clr,
  output logic             pressed,
  output logic [CNT_W-1:0] tally
);

  logic [CNT_W-1:0] on_run, on_run_next;
  logic [CNT_W-1:0] off_run, off_run_next;
  logic [CNT_W-1:0] held, held_next;
  logic [CNT_W-1:0] phase, phase_next;
  logic [CNT_W-1:0] tally_next;
  logic             pressed_next;

  logic [CNT_W-1:0] on_inc, off_inc, held_inc, phase_inc;
  logic             press_hit, release_hit, held_moved;
  logic             rep_en, first_rep, period_hit;
  logic             bump;

  assign on_inc      = sat_inc(on_run);
  assign off_inc     = sat_inc(off_run);
  assign held_inc    = sat_inc(held);
  assign phase_inc   = sat_inc(phase);
  assign press_hit   = (on_run != SAT) && (on_inc == cfg.on_deb);
  assign release_hit = (off_run != SAT) && (off_inc == cfg.off_deb);
  assign held_moved  = (held != SAT);
  assign rep_en      = (cfg.rep_delay != '0) && (held_inc >= cfg.rep_delay);
  assign first_rep   = held_moved && (held_inc == cfg.rep_delay);
  assign period_hit  = (phase_inc == cfg.rep_period);

  always_comb begin
    on_run_next  = on_run;
    off_run_next = off_run;
    held_next    = held;
    phase_next   = phase;
    pressed_next = pressed;
    bump         = 1'b0;
    if (tick) begin
      if (!raw_bit) begin
        off_run_next = '0;
        on_run_next  = on_inc;
        if (press_hit) begin
          held_next    = '0;
          phase_next   = '0;
          pressed_next = 1'b1;
          bump         = 1'b1;
        end else if (pressed) begin
          held_next = held_inc;
          if (rep_en) begin
            if (first_rep || period_hit) begin
              phase_next = '0;
              bump       = 1'b1;
            end else begin
              phase_next = phase_inc;
            end
          end
        end
      end else begin
        off_run_next = off_inc;
        on_run_next  = '0;
        held_next    = '0;
        phase_next   = '0;
        if (release_hit) pressed_next = 1'b0;
      end
    end
    if (clr) tally_next = '0;
    else if (bump) tally_next = sat_inc(tally);
    else tally_next = tally;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on_run  <= '0;
      off_run <= '0;
      held    <= '0;
      phase   <= '0;
      pressed <= 1'b0;
      tally   <= '0;
    end else begin
      on_run  <= on_run_next;
      off_run <= off_run_next;
      held    <= held_next;
      phase   <= phase_next;
      pressed <= pressed_next;
      tally   <= tally_next;
    end
  end

  a_press_on_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(pressed) |-> ($past(tick) && !$past(raw_bit)))
    else $error("press without a closed sample");

  a_tally_monotonic: assert property (@(posedge clk) disable iff (rst)
    !clr |=> (tally >= $past(tally)))
    else $error("tally dropped without a clear");

  a_runs_excl: assert property (@(posedge clk) disable iff (rst)
    !((on_run != '0) && (off_run != '0)))
    else $error("open and closed runs both active");

endmodule

// ===== rtl/core/sda_back.sv =====
// Execution side: applies ticks to all lanes, sequences collect results.
// Depends on sda_pkg; drives the lane control and the output register.
module sda_back import sda_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  sda_item_t                     q_item,
  input  logic [SWITCHES-1:0]           pressed,
  input  logic [SWITCHES-1:0][CNT_W-1:0] tally,
  output sda_lane_ctl_t                 ctl,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sda_out_t                      out_data
);

  typedef enum logic {
    ST_IDLE,
    ST_COLLECT
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] idx;
  logic             load;
  logic             idx_last;
  logic [31:0]      idx_wide;

  assign q_ready  = (state == ST_IDLE);
  assign load     = (state == ST_COLLECT) && (!out_valid || out_ready);
  assign idx_last = (idx == IDX_W'(SWITCHES - 1));
  assign idx_wide = 32'(idx);

  always_comb begin
    ctl.tick    = (state == ST_IDLE) && q_valid && (q_item.op == OP_TICK);
    ctl.clr     = load;
    ctl.clr_idx = idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid && (q_item.op == OP_COLLECT)) begin
            state <= ST_COLLECT;
            idx   <= '0;
          end
        end
        ST_COLLECT: begin
          if (load) begin
            out_data.switch_index   <= idx_wide[3:0];
            out_data.switch_pressed <= pressed[idx];
            out_data.press_count    <= tally[idx];
            out_data.last           <= idx_last;
            if (idx_last) state <= ST_IDLE;
            else idx <= idx + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (load && idx_last) |=> (state == ST_IDLE && out_valid && out_data.last))
    else $error("collect run did not end on its last result");

  a_tick_clr_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctl.tick && ctl.clr))
    else $error("tick applied during a collect");

  a_first_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && q_valid && q_item.op == OP_COLLECT) |=> (idx == '0))
    else $error("collect run did not start at switch zero");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for switch_debounce_autorepeat: random ticks and collects
// go in, each collect report is checked against an in-bench debounce model.
// Depends on sda_pkg and the switch_debounce_autorepeat RTL.
module tb_top;
  import sda_pkg::*;

  localparam logic CMD_TICK = 1'b0;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int MAX_ERR_LINES = 30;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  sda_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  sda_out_t             out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0]     cfg_data = '0;

  switch_debounce_autorepeat dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // debounce model state
  sda_cfg_t         cfg_shadow = '{RST_ON_DEB, RST_OFF_DEB, RST_REP_DELAY, RST_REP_PERIOD};
  logic [CNT_W-1:0] close_run   [SWITCHES];
  logic [CNT_W-1:0] open_run    [SWITCHES];
  logic             is_down     [SWITCHES];
  logic [CNT_W-1:0] hold_time   [SWITCHES];
  logic [CNT_W-1:0] rep_phase   [SWITCHES];
  logic [CNT_W-1:0] press_tally [SWITCHES];

  sda_in_t  pending_items[$];
  sda_out_t expected_reports[$];
  int       mismatches = 0;
  bit       steady = 1'b0;
  int       send_wait = 0;
  int       recv_wait = 0;
  int       recv_draw;
  sda_out_t want;
  logic [SAMPLE_W-1:0] level_word = '1;
  int unsigned cycle_count = 0;

  initial begin
    for (int i = 0; i < SWITCHES; i++) begin
      close_run[i] = '0;
      open_run[i] = '0;
      is_down[i] = 1'b0;
      hold_time[i] = '0;
      rep_phase[i] = '0;
      press_tally[i] = '0;
    end
  end

  function automatic bit inc_sat(inout logic [CNT_W-1:0] c);
    if (c == 16'hFFFF) return 1'b0;
    c = c + 1'b1;
    return 1'b1;
  endfunction

  function automatic void debounce_tick(input logic [SAMPLE_W-1:0] sample);
    bit moved;
    bit held_moved;
    for (int i = 0; i < SWITCHES; i++) begin
      if (!sample[i % SAMPLE_W]) begin
        moved = inc_sat(close_run[i]);
        if (moved && close_run[i] == cfg_shadow.on_deb) begin
          hold_time[i] = '0;
          rep_phase[i] = '0;
          is_down[i] = 1'b1;
          void'(inc_sat(press_tally[i]));
        end else if (is_down[i]) begin
          held_moved = inc_sat(hold_time[i]);
          if (cfg_shadow.rep_delay != 0 && hold_time[i] >= cfg_shadow.rep_delay) begin
            if (held_moved && hold_time[i] == cfg_shadow.rep_delay) begin
              rep_phase[i] = '0;
              void'(inc_sat(press_tally[i]));
            end else begin
              void'(inc_sat(rep_phase[i]));
              if (rep_phase[i] == cfg_shadow.rep_period) begin
                rep_phase[i] = '0;
                void'(inc_sat(press_tally[i]));
              end
            end
          end
        end
        open_run[i] = '0;
      end else begin
        moved = inc_sat(open_run[i]);
        if (moved && open_run[i] == cfg_shadow.off_deb) is_down[i] = 1'b0;
        close_run[i] = '0;
        hold_time[i] = '0;
        rep_phase[i] = '0;
      end
    end
  endfunction

  function automatic void collect_states();
    sda_out_t rpt;
    for (int i = 0; i < SWITCHES; i++) begin
      rpt.switch_index = 4'(i);
      rpt.switch_pressed = is_down[i];
      rpt.press_count = press_tally[i];
      rpt.last = (i == SWITCHES - 1);
      expected_reports.push_back(rpt);
      press_tally[i] = '0;
    end
  endfunction

  function automatic int draw_gap();
    if (steady) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(1, 12);
  endfunction

  task automatic flag_error(input string what);
    mismatches++;
    if (mismatches <= MAX_ERR_LINES) $display("ERROR @%0t: %s", $time, what);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (in_valid && in_ready) begin
        if (in_data.cmd == CMD_COLLECT) collect_states();
        else debounce_tick(in_data.raw_sample);
      end
      if (!in_valid || in_ready) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          send_wait <= draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          flag_error($sformatf("result with nothing expected: %h", out_data));
        end else begin
          want = expected_reports.pop_front();
          if (out_data !== want)
            flag_error($sformatf({"report mismatch: got idx=%0d pressed=%0b count=%0d last=%0b,",
                                  " want idx=%0d pressed=%0b count=%0d last=%0b"},
                                 out_data.switch_index, out_data.switch_pressed,
                                 out_data.press_count, out_data.last, want.switch_index,
                                 want.switch_pressed, want.press_count, want.last));
        end
        recv_draw = draw_gap();
        recv_wait <= recv_draw;
        out_ready <= (recv_draw == 0);
      end else if (recv_wait != 0) begin
        recv_wait <= recv_wait - 1;
        out_ready <= (recv_wait == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** switch_debounce_autorepeat: FAILED **");
      $finish;
    end
  end

  task automatic queue_item(input logic cmd, input logic [SAMPLE_W-1:0] smp);
    sda_in_t item;
    item.cmd = cmd;
    item.raw_sample = smp;
    pending_items.push_back(item);
  endtask

  // wait until every transfer is done and the pipeline has gone quiet
  task automatic settle();
    while (pending_items.size() != 0 || in_valid || expected_reports.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_ON_DEB:     cfg_shadow.on_deb = val;
      REG_OFF_DEB:    cfg_shadow.off_deb = val;
      REG_REP_DELAY:  cfg_shadow.rep_delay = val;
      REG_REP_PERIOD: cfg_shadow.rep_period = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [CNT_W-1:0] on_t, off_t, dly, per);
    write_reg(REG_ON_DEB, on_t);
    write_reg(REG_OFF_DEB, off_t);
    write_reg(REG_REP_DELAY, dly);
    write_reg(REG_REP_PERIOD, per);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // mostly slow level changes with single-tick bounce, occasional noise words and collects
  task automatic random_run(input int n);
    logic [SAMPLE_W-1:0] smp;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_item(CMD_COLLECT, 16'($urandom));
      end else begin
        if ($urandom_range(0, 3) == 0) level_word ^= 16'($urandom & $urandom & $urandom);
        smp = level_word;
        if ($urandom_range(0, 4) == 0) smp ^= 16'd1 << $urandom_range(0, 15);
        if ($urandom_range(0, 24) == 0) smp = 16'($urandom);
        queue_item(CMD_TICK, smp);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset defaults: press, release attempt, bounce and re-press
    queue_item(CMD_COLLECT, 16'hFFFF);
    repeat (4) queue_item(CMD_TICK, 16'h0000);
    queue_item(CMD_COLLECT, 16'h0000);
    repeat (2) queue_item(CMD_TICK, 16'hFFFF);
    queue_item(CMD_TICK, 16'hAAAA);
    queue_item(CMD_TICK, 16'h5555);
    repeat (4) queue_item(CMD_TICK, 16'h0000);
    queue_item(CMD_COLLECT, 16'h1234);
    queue_item(CMD_COLLECT, 16'h0000);
    settle();

    for (int p = 0; p < 3; p++) begin
      steady = (p == 1);
      set_config(16'($urandom_range(1, 5)), 16'($urandom_range(1, 6)),
                 ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 6)),
                 16'($urandom_range(1, 4)));
      random_run(12);
      settle();
      random_run(12);
      queue_item(CMD_COLLECT, 16'h0000);
      settle();
    end

    steady = 1'b0;
    set_config(16'd0, 16'd0, 16'd65534, 16'd65535);
    random_run(12);
    queue_item(CMD_COLLECT, 16'h0000);
    settle();

    set_config(16'd65534, 16'd1, 16'd1, 16'd65535);
    random_run(12);
    queue_item(CMD_COLLECT, 16'h0000);
    settle();

    // long hold with a repeat on every tick
    steady = 1'b1;
    set_config(16'd1, 16'd65534, 16'd1, 16'd1);
    queue_item(CMD_TICK, 16'h0000);
    repeat (30) queue_item(CMD_TICK, {2'($urandom), 2'b11, 12'h000});
    queue_item(CMD_COLLECT, 16'h0000);
    repeat (5) queue_item(CMD_TICK, 16'hF000);
    queue_item(CMD_COLLECT, 16'h0000);
    settle();

    steady = 1'b0;
    set_config(RST_ON_DEB, RST_OFF_DEB, RST_REP_DELAY, RST_REP_PERIOD);
    random_run(12);
    queue_item(CMD_COLLECT, 16'h0000);
    settle();

    if (mismatches == 0) begin
      $display("** switch_debounce_autorepeat: PASSED **");
    end else begin
      $display("** switch_debounce_autorepeat: FAILED **");
    end
    $finish;
  end

endmodule
